// ----- hw/rtl/wav_header_stream_parser_defines.svh -----
// ----------------------------------------------------------------------------
// WAV header stream parser assertion macros
// Concurrent assertion helpers shared by the parser RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_STREAM_PARSER_DEFINES_SVH
`define WAV_HEADER_STREAM_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define WAVHDR_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("wavhdr: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define WAVHDR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("wavhdr: next-cycle check failed");

`else

`define WAVHDR_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define WAVHDR_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- hw/rtl/wavhdr_pkg.sv -----
// ----------------------------------------------------------------------------
// wavhdr_pkg
// Shared codes, constants and types of the WAV header stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package wavhdr_pkg;

    // Parser modes
    localparam logic [2:0] MODE_FIXED   = 3'd0;
    localparam logic [2:0] MODE_CHUNK   = 3'd1;
    localparam logic [2:0] MODE_SKIP    = 3'd2;
    localparam logic [2:0] MODE_PAYLOAD = 3'd3;
    localparam logic [2:0] MODE_DONE    = 3'd4;
    localparam logic [2:0] MODE_REJECT  = 3'd5;

    // Result kinds
    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_SKIP    = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD = 3'd2;
    localparam logic [2:0] KIND_REJECT  = 3'd3;
    localparam logic [2:0] KIND_IGNORED = 3'd4;

    // Chunk id "data" as read little-endian
    localparam logic [31:0] DATA_ID = 32'h6174_6164;

    // Last byte index of the fixed RIFF/WAVE/fmt header
    localparam logic [5:0] FIXED_LAST_POS = 6'd35;

    // Expected magic byte at fixed header offsets 0..15 (size bytes 4..7 unused)
    function automatic logic [7:0] magic_byte(input logic [3:0] idx);
        logic [7:0] val;
        case (idx)
            4'd0:    val = 8'h52; // R
            4'd1:    val = 8'h49; // I
            4'd2:    val = 8'h46; // F
            4'd3:    val = 8'h46; // F
            4'd8:    val = 8'h57; // W
            4'd9:    val = 8'h41; // A
            4'd10:   val = 8'h56; // V
            4'd11:   val = 8'h45; // E
            4'd12:   val = 8'h66; // f
            4'd13:   val = 8'h6d; // m
            4'd14:   val = 8'h74; // t
            4'd15:   val = 8'h20; // space
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    // One result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic        header_valid;
        logic [15:0] audio_format;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [31:0] data_size;
    } wav_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wavhdr_parser.sv -----
// ----------------------------------------------------------------------------
// wavhdr_parser
// Parse state and captured fmt fields; computes the result of one byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wav_header_stream_parser_defines.svh"

module wavhdr_parser (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     step_en,
    input  wire logic [7:0]               in_byte,
    input  wire logic                     restart,
    output wavhdr_pkg::wav_result_t       res
);

    import wavhdr_pkg::*;

    // State registers
    logic [2:0]  mode_reg,   mode_next;
    logic [5:0]  pos_reg,    pos_next;
    logic [31:0] word_reg,   word_next;
    logic [31:0] rem_reg,    rem_next;
    logic [15:0] fmt_reg,    fmt_next;
    logic [15:0] chan_reg,   chan_next;
    logic [31:0] rate_reg,   rate_next;
    logic [31:0] brate_reg,  brate_next;
    logic [15:0] align_reg,  align_next;
    logic [15:0] bits_reg,   bits_next;
    logic [31:0] dsize_reg,  dsize_next;
    logic        header_reg, header_next;

    // State seen by this byte: reset values when restart is set
    logic [2:0]  base_mode;
    logic [5:0]  base_pos;
    logic [31:0] base_word;
    logic [31:0] base_rem;
    logic [15:0] base_fmt;
    logic [15:0] base_chan;
    logic [31:0] base_rate;
    logic [31:0] base_brate;
    logic [15:0] base_align;
    logic [15:0] base_bits;
    logic [31:0] base_dsize;
    logic        base_header;

    logic [2:0]  kind;
    logic [7:0]  pay;
    logic        last;
    logic [2:0]  lane_pos;
    logic [31:0] lane_val;
    logic [31:0] rem_dec;
    logic        magic_slot;

    always_comb begin
        base_mode   = restart ? MODE_FIXED : mode_reg;
        base_pos    = restart ? 6'd0  : pos_reg;
        base_word   = restart ? 32'd0 : word_reg;
        base_rem    = restart ? 32'd0 : rem_reg;
        base_fmt    = restart ? 16'd0 : fmt_reg;
        base_chan   = restart ? 16'd0 : chan_reg;
        base_rate   = restart ? 32'd0 : rate_reg;
        base_brate  = restart ? 32'd0 : brate_reg;
        base_align  = restart ? 16'd0 : align_reg;
        base_bits   = restart ? 16'd0 : bits_reg;
        base_dsize  = restart ? 32'd0 : dsize_reg;
        base_header = restart ? 1'b0  : header_reg;
    end

    // Next state and result of one byte
    always_comb begin
        mode_next   = base_mode;
        pos_next    = base_pos;
        word_next   = base_word;
        rem_next    = base_rem;
        fmt_next    = base_fmt;
        chan_next   = base_chan;
        rate_next   = base_rate;
        brate_next  = base_brate;
        align_next  = base_align;
        bits_next   = base_bits;
        dsize_next  = base_dsize;
        header_next = base_header;
        kind        = KIND_IGNORED;
        pay         = 8'd0;
        last        = 1'b0;
        lane_pos    = base_pos[2:0];
        lane_val    = {24'd0, in_byte} << {lane_pos[1:0], 3'b000};
        rem_dec     = base_rem - 32'd1;
        magic_slot  = (base_pos < 6'd16) && ((base_pos < 6'd4) || (base_pos >= 6'd8));

        unique case (base_mode)
            MODE_FIXED: begin
                if (magic_slot && (in_byte != magic_byte(base_pos[3:0]))) begin
                    mode_next = MODE_REJECT;
                    kind      = KIND_REJECT;
                end else begin
                    kind = KIND_HEADER;
                    // little-endian fmt field capture
                    case (base_pos)
                        6'd20:   fmt_next[7:0]     = in_byte;
                        6'd21:   fmt_next[15:8]    = in_byte;
                        6'd22:   chan_next[7:0]    = in_byte;
                        6'd23:   chan_next[15:8]   = in_byte;
                        6'd24:   rate_next[7:0]    = in_byte;
                        6'd25:   rate_next[15:8]   = in_byte;
                        6'd26:   rate_next[23:16]  = in_byte;
                        6'd27:   rate_next[31:24]  = in_byte;
                        6'd28:   brate_next[7:0]   = in_byte;
                        6'd29:   brate_next[15:8]  = in_byte;
                        6'd30:   brate_next[23:16] = in_byte;
                        6'd31:   brate_next[31:24] = in_byte;
                        6'd32:   align_next[7:0]   = in_byte;
                        6'd33:   align_next[15:8]  = in_byte;
                        6'd34:   bits_next[7:0]    = in_byte;
                        6'd35:   bits_next[15:8]   = in_byte;
                        default: ;
                    endcase
                    if (base_pos >= FIXED_LAST_POS) begin
                        mode_next = MODE_CHUNK;
                        pos_next  = 6'd0;
                        word_next = 32'd0;
                        rem_next  = 32'd0;
                    end else begin
                        pos_next = base_pos + 6'd1;
                    end
                end
            end
            MODE_CHUNK: begin
                kind = KIND_HEADER;
                // id in bytes 0..3, size in bytes 4..7
                if (!lane_pos[2]) begin
                    word_next = base_word | lane_val;
                end else begin
                    rem_next = base_rem | lane_val;
                end
                if (lane_pos != 3'd7) begin
                    pos_next = {3'd0, lane_pos} + 6'd1;
                end else begin
                    pos_next = 6'd0;
                    if (word_next == DATA_ID) begin
                        dsize_next  = rem_next;
                        header_next = 1'b1;
                        mode_next   = (rem_next == 32'd0) ? MODE_DONE : MODE_PAYLOAD;
                    end else if (rem_next == 32'd0) begin
                        word_next = 32'd0;
                    end else begin
                        pos_next  = {5'd0, rem_next[0]};
                        mode_next = MODE_SKIP;
                    end
                end
            end
            MODE_SKIP: begin
                kind     = KIND_SKIP;
                rem_next = rem_dec;
                if (rem_dec == 32'd0) begin
                    if (base_pos[0]) begin
                        // odd chunk: one pad byte still to skip
                        rem_next = 32'd1;
                        pos_next = 6'd0;
                    end else begin
                        mode_next = MODE_CHUNK;
                        pos_next  = 6'd0;
                        word_next = 32'd0;
                    end
                end
            end
            MODE_PAYLOAD: begin
                kind     = KIND_PAYLOAD;
                pay      = in_byte;
                rem_next = rem_dec;
                if (rem_dec == 32'd0) begin
                    last      = 1'b1;
                    mode_next = MODE_DONE;
                end
            end
            default: begin
                kind = KIND_IGNORED;
            end
        endcase
    end

    // Result reflects state after this byte
    always_comb begin
        res.kind          = kind;
        res.payload_byte  = pay;
        res.payload_last  = last;
        res.header_valid  = header_next;
        res.audio_format  = fmt_next;
        res.channel_count = chan_next;
        res.sample_rate   = rate_next;
        res.byte_rate     = brate_next;
        res.block_align   = align_next;
        res.sample_bits   = bits_next;
        res.data_size     = dsize_next;
    end

    // State update on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_FIXED;
            pos_reg    <= 6'd0;
            word_reg   <= 32'd0;
            rem_reg    <= 32'd0;
            fmt_reg    <= 16'd0;
            chan_reg   <= 16'd0;
            rate_reg   <= 32'd0;
            brate_reg  <= 32'd0;
            align_reg  <= 16'd0;
            bits_reg   <= 16'd0;
            dsize_reg  <= 32'd0;
            header_reg <= 1'b0;
        end else if (step_en) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            word_reg   <= word_next;
            rem_reg    <= rem_next;
            fmt_reg    <= fmt_next;
            chan_reg   <= chan_next;
            rate_reg   <= rate_next;
            brate_reg  <= brate_next;
            align_reg  <= align_next;
            bits_reg   <= bits_next;
            dsize_reg  <= dsize_next;
            header_reg <= header_next;
        end
    end

    // Counting modes always have bytes left; payload only after the data header
    `WAVHDR_ASSERT_IMPL(a_payload_rem, aclk, aresetn, mode_reg == MODE_PAYLOAD, rem_reg != 32'd0)
    `WAVHDR_ASSERT_IMPL(a_skip_rem, aclk, aresetn, mode_reg == MODE_SKIP, rem_reg != 32'd0)
    `WAVHDR_ASSERT_IMPL(a_payload_hdr, aclk, aresetn, mode_reg == MODE_PAYLOAD, header_reg)
    `WAVHDR_ASSERT_IMPL(a_chunk_pos, aclk, aresetn, mode_reg == MODE_CHUNK, pos_reg < 6'd8)

endmodule

`default_nettype wire

// ----- hw/rtl/wav_header_stream_parser.sv -----
// ----------------------------------------------------------------------------
// wav_header_stream_parser
// RIFF/WAVE byte stream parser: header check, fmt capture, data pass-through.
// ----------------------------------------------------------------------------
// The block takes one byte of a WAV file per transfer and returns one registered
// result per byte, at a sustained rate of one byte per clock while m_ready stays
// high: each byte updates the parse state and loads a single output
// register, and a new byte is taken whenever that register is empty or being
// emptied in the same cycle. s_restart on a byte restarts parsing at that
// byte. Captured fmt fields and data_size accompany every result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wav_header_stream_parser_defines.svh"

module wav_header_stream_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // byte input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_restart,
    // result output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_kind,
    output logic [7:0]       m_payload_byte,
    output logic             m_payload_last,
    output logic             m_header_valid,
    output logic [15:0]      m_audio_format,
    output logic [15:0]      m_channel_count,
    output logic [31:0]      m_sample_rate,
    output logic [31:0]      m_byte_rate,
    output logic [15:0]      m_block_align,
    output logic [15:0]      m_sample_bits,
    output logic [31:0]      m_data_size
);

    import wavhdr_pkg::*;

    logic        s_xfer;
    logic        m_valid_reg;
    wav_result_t step_res;
    wav_result_t out_reg;

    // Take a byte when the output register is free or drains this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    wavhdr_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (s_xfer),
        .in_byte (s_in_byte),
        .restart (s_restart),
        .res     (step_res)
    );

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            out_reg <= step_res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = out_reg.kind;
    assign m_payload_byte  = out_reg.payload_byte;
    assign m_payload_last  = out_reg.payload_last;
    assign m_header_valid  = out_reg.header_valid;
    assign m_audio_format  = out_reg.audio_format;
    assign m_channel_count = out_reg.channel_count;
    assign m_sample_rate   = out_reg.sample_rate;
    assign m_byte_rate     = out_reg.byte_rate;
    assign m_block_align   = out_reg.block_align;
    assign m_sample_bits   = out_reg.sample_bits;
    assign m_data_size     = out_reg.data_size;

    // Every taken byte shows up as a result next cycle
    `WAVHDR_ASSERT_NEXT(a_xfer_result, aclk, aresetn, s_xfer, m_valid_reg)
    // Last flag only rides on a payload byte
    `WAVHDR_ASSERT_IMPL(a_last_kind, aclk, aresetn, m_valid_reg && out_reg.payload_last, out_reg.kind == KIND_PAYLOAD)

endmodule

`default_nettype wire
